FILE: hw/rtl/timer_slot_pool_with_watchers_macros.svh
// assertion macros shared by the checker of the timer slot pool
`ifndef TIMER_SLOT_POOL_WITH_WATCHERS_MACROS_SVH
`define TIMER_SLOT_POOL_WITH_WATCHERS_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define TSPW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/tspw_pkg.sv
// shared types and constants of the timer slot pool
package tspw_pkg;

   localparam int SLOT_COUNT_DEFAULT    = 8;
   localparam int WATCHER_COUNT_DEFAULT = 4;

   localparam int CMD_W   = 2;
   localparam int DUR_W   = 32;
   localparam int WIDX_W  = 2;
   localparam int SIDX_W  = 3;
   localparam int MASK_W  = 8;
   localparam int RUN_W   = 4;
   localparam int RES_W   = 8;

   localparam logic [RES_W-1:0] RES_RESET = 8'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_LOAD  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_APPLY,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic             done;
      logic             zero;
      logic [DUR_W-1:0] ticks;
   } div_result_type;

   typedef struct packed {
      logic             tick;
      logic             start;
      logic             ticks_zero;
      logic [DUR_W-1:0] ticks;
   } slot_ctl_type;

   typedef struct packed {
      logic             tick;
      logic             load;
      logic [DUR_W-1:0] ticks;
   } watch_ctl_type;

endpackage

FILE: hw/rtl/tspw_channels.sv
// valid/ready channel interfaces of the timer slot pool
interface tspw_req_if;
   import tspw_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [DUR_W-1:0]    duration_us;
   logic [WIDX_W-1:0]   watcher_index;

   modport source (output valid, command, duration_us, watcher_index, input ready);
   modport sink   (input valid, command, duration_us, watcher_index, output ready);
   modport monitor (input valid, ready, command, duration_us, watcher_index);
endinterface

interface tspw_rsp_if;
   import tspw_pkg::*;
   logic                valid;
   logic                ready;
   logic [SIDX_W-1:0]   slot_index;
   logic                alloc_failed;
   logic [MASK_W-1:0]   expired_slots;
   logic [MASK_W-1:0]   busy_slots;
   logic [RUN_W-1:0]    watchers_running;

   modport source (output valid, slot_index, alloc_failed, expired_slots, busy_slots,
                   watchers_running, input ready);
   modport sink   (input valid, slot_index, alloc_failed, expired_slots, busy_slots,
                   watchers_running, output ready);
   modport monitor (input valid, ready, slot_index, alloc_failed, expired_slots,
                    busy_slots, watchers_running);
endinterface

interface tspw_csr_if;
   import tspw_pkg::*;
   logic                valid;
   logic                ready;
   logic [RES_W-1:0]    tick_resolution_us;

   modport source (output valid, tick_resolution_us, input ready);
   modport sink   (input valid, tick_resolution_us, output ready);
   modport monitor (input valid, ready, tick_resolution_us);
endinterface

FILE: hw/rtl/timer_slot_pool_with_watchers.sv
// Timer slot pool with link watchers. One request beat in, one response beat out.
// A tick (or command 3) goes from its request beat straight to update and report; a start or a
// watcher load first waits for the bit-serial divider that turns the duration into ticks
// (32 quotient steps, one rounding step), then updates and reports.
// One request is in flight at a time; the response sits in an output register, so the
// next request is taken while the previous response still waits. The slots form a row
// of cells joined by a free-slot chain that picks the lowest free slot.
module timer_slot_pool_with_watchers #(
   parameter int SLOT_COUNT    = tspw_pkg::SLOT_COUNT_DEFAULT,
   parameter int WATCHER_COUNT = tspw_pkg::WATCHER_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tspw_req_if.sink    req_bus,
   tspw_rsp_if.source  rsp_bus,
   tspw_csr_if.sink    csr_bus
);
   import tspw_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff;
   logic [WIDX_W-1:0]   widx_ff;
   logic [RES_W-1:0]    res_ff;

   logic                req_take;
   logic                need_div;
   logic                div_start;
   logic                apply;
   logic                report_load;
   div_result_type      div_res;

   slot_ctl_type        slot_ctl;
   watch_ctl_type       watch_ctl;
   logic [SLOT_COUNT:0] claim;
   logic [SLOT_COUNT-1:0] busy_vec;
   logic [SLOT_COUNT-1:0] expire_vec;
   logic [SLOT_COUNT-1:0] taken_vec;
   logic [WATCHER_COUNT-1:0] run_vec;
   logic [WATCHER_COUNT-1:0] sel_vec;

   logic [IDX_W-1:0]    claim_idx;
   logic [IDX_W+SIDX_W-1:0] claim_idx_ext;
   logic [SLOT_COUNT+MASK_W-1:0] busy_ext;
   logic [SLOT_COUNT+MASK_W-1:0] expired_ext;
   logic [WATCHER_COUNT+RUN_W-1:0] run_ext;

   logic [SLOT_COUNT-1:0] expired_ff;
   logic [SIDX_W-1:0]   idx_ff;
   logic                failed_ff;

   logic                rsp_valid_ff;
   logic [SIDX_W-1:0]   rsp_idx_ff;
   logic                rsp_failed_ff;
   logic [MASK_W-1:0]   rsp_expired_ff;
   logic [MASK_W-1:0]   rsp_busy_ff;
   logic [RUN_W-1:0]    rsp_run_ff;

   // configuration
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
      end else if (csr_bus.valid) begin
         res_ff <= csr_bus.tick_resolution_us;
      end
   end

   // sequencer
   assign req_take = req_bus.valid && req_bus.ready;

   always_comb begin
      unique case (cmd_type'(req_bus.command)) inside
         CMD_START, CMD_LOAD: need_div = 1'b1;
         default:             need_div = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = need_div ? ST_DIVIDE : ST_APPLY;
            end
         end
         ST_DIVIDE: begin
            if (div_res.done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      div_start     = 1'b0;
      apply         = 1'b0;
      report_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            div_start     = req_bus.valid && need_div;
         end
         ST_DIVIDE: ;
         ST_APPLY:  apply = 1'b1;
         ST_REPORT: report_load = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= cmd_type'(req_bus.command);
         widx_ff <= req_bus.watcher_index;
      end
   end

   tspw_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_bus.duration_us),
      .divisor  (res_ff),
      .result   (div_res)
   );

   // slot row
   always_comb begin
      slot_ctl.tick       = apply && (cmd_ff == CMD_TICK);
      slot_ctl.start      = apply && (cmd_ff == CMD_START);
      slot_ctl.ticks_zero = div_res.zero;
      slot_ctl.ticks      = div_res.ticks;
      watch_ctl.tick      = apply && (cmd_ff == CMD_TICK);
      watch_ctl.load      = apply && (cmd_ff == CMD_LOAD);
      watch_ctl.ticks     = div_res.ticks;
   end

   assign claim[0] = 1'b1;

   for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
      tspw_slot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (slot_ctl),
         .claim_in  (claim[s]),
         .claim_out (claim[s+1]),
         .busy      (busy_vec[s]),
         .expire    (expire_vec[s]),
         .taken     (taken_vec[s])
      );
   end

   // watcher index wraps modulo the watcher count
   always_comb begin
      sel_vec = '0;
      for (int w = 0; w < WATCHER_COUNT; w++) begin
         for (int k = 0; k < (1 << WIDX_W); k++) begin
            if (((k % WATCHER_COUNT) == w) && (widx_ff == WIDX_W'(k))) begin
               sel_vec[w] = 1'b1;
            end
         end
      end
   end

   for (genvar w = 0; w < WATCHER_COUNT; w++) begin : g_watch
      tspw_watch_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (watch_ctl),
         .sel     (sel_vec[w]),
         .running (run_vec[w])
      );
   end

   always_comb begin
      claim_idx = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (taken_vec[s]) begin
            claim_idx = claim_idx | IDX_W'(s);
         end
      end
   end

   assign claim_idx_ext = {{SIDX_W{1'b0}}, claim_idx};
   assign busy_ext      = {{MASK_W{1'b0}}, busy_vec};
   assign expired_ext   = {{MASK_W{1'b0}}, expired_ff};
   assign run_ext       = {{RUN_W{1'b0}}, run_vec};

   always_ff @(posedge clock) begin
      if (apply) begin
         expired_ff <= expire_vec;
         idx_ff     <= claim_idx_ext[SIDX_W-1:0];
         failed_ff  <= slot_ctl.start && claim[SLOT_COUNT];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (report_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (report_load) begin
         rsp_idx_ff     <= idx_ff;
         rsp_failed_ff  <= failed_ff;
         rsp_expired_ff <= expired_ext[MASK_W-1:0];
         rsp_busy_ff    <= busy_ext[MASK_W-1:0];
         rsp_run_ff     <= run_ext[RUN_W-1:0];
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.slot_index       = rsp_idx_ff;
   assign rsp_bus.alloc_failed     = rsp_failed_ff;
   assign rsp_bus.expired_slots    = rsp_expired_ff;
   assign rsp_bus.busy_slots       = rsp_busy_ff;
   assign rsp_bus.watchers_running = rsp_run_ff;

endmodule

FILE: hw/rtl/tspw_divider.sv
// bit-serial ceiling divider: duration over tick resolution, one quotient bit a cycle
module tspw_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tspw_pkg::DUR_W-1:0]  dividend,
   input  logic [tspw_pkg::RES_W-1:0]  divisor,
   output tspw_pkg::div_result_type    result
);
   import tspw_pkg::*;

   localparam int CNT_W = $clog2(DUR_W + 1);

   logic               active_ff, active_in;
   logic               round_ff, round_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DUR_W-1:0]   quo_ff, quo_in;
   logic [RES_W-1:0]   rem_ff, rem_in;
   logic [RES_W-1:0]   dsr_ff, dsr_in;
   logic [DUR_W-1:0]   ticks_ff, ticks_in;
   logic               zero_ff, zero_in;
   logic [RES_W:0]     trial;
   logic [RES_W:0]     diff;

   always_comb begin
      trial     = {rem_ff, quo_ff[DUR_W-1]};
      diff      = trial - {1'b0, dsr_ff};
      active_in = active_ff;
      round_in  = round_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      ticks_in  = ticks_ff;
      zero_in   = zero_ff;
      if (start) begin
         active_in = 1'b1;
         round_in  = 1'b0;
         count_in  = CNT_W'(DUR_W);
         quo_in    = dividend;
         rem_in    = '0;
         // a zero resolution divides by one
         dsr_in    = (divisor == '0) ? RES_W'(1) : divisor;
      end else if (active_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[RES_W-1:0];
            quo_in = {quo_ff[DUR_W-2:0], 1'b1};
         end else begin
            rem_in = trial[RES_W-1:0];
            quo_in = {quo_ff[DUR_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            round_in  = 1'b1;
         end
      end else if (round_ff) begin
         // round up on a nonzero remainder
         ticks_in = quo_ff + DUR_W'(rem_ff != '0);
         zero_in  = (quo_ff == '0) && (rem_ff == '0);
         round_in = 1'b0;
         done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         round_ff  <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         round_ff  <= round_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      ticks_ff <= ticks_in;
      zero_ff  <= zero_in;
   end

   assign result.done  = done_ff;
   assign result.zero  = zero_ff;
   assign result.ticks = ticks_ff;

endmodule

FILE: hw/rtl/tspw_slot_cell.sv
// one countdown slot of the pool, linked to its neighbours by the free-slot chain
module tspw_slot_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tspw_pkg::slot_ctl_type ctl,
   input  logic                   claim_in,
   output logic                   claim_out,
   output logic                   busy,
   output logic                   expire,
   output logic                   taken
);
   import tspw_pkg::*;

   logic [DUR_W-1:0] rem_ff, rem_in;
   logic             busy_ff, busy_in;
   logic             last_tick;

   // claim_in high means every lower slot is busy
   assign taken     = ctl.start && claim_in && !busy_ff;
   assign claim_out = claim_in && busy_ff;
   assign last_tick = (rem_ff == '0) || (rem_ff == DUR_W'(1));
   assign expire    = (ctl.tick && busy_ff && last_tick) || (taken && ctl.ticks_zero);

   always_comb begin
      rem_in  = rem_ff;
      busy_in = busy_ff;
      if (ctl.tick && busy_ff) begin
         rem_in  = rem_ff - DUR_W'(rem_ff != '0);
         busy_in = !last_tick;
      end else if (taken) begin
         rem_in  = ctl.ticks;
         busy_in = !ctl.ticks_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         rem_ff  <= rem_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

FILE: hw/rtl/tspw_watch_cell.sv
// one link watchdog counter
module tspw_watch_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tspw_pkg::watch_ctl_type ctl,
   input  logic                    sel,
   output logic                    running
);
   import tspw_pkg::*;

   logic [DUR_W-1:0] rem_ff, rem_in;

   always_comb begin
      rem_in = rem_ff;
      if (ctl.tick) begin
         rem_in = rem_ff - DUR_W'(rem_ff != '0);
      end else if (ctl.load && sel) begin
         rem_in = ctl.ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   assign running = (rem_ff != '0);

endmodule

FILE: hw/rtl/tspw_checker.sv
// port-level assertions of the timer slot pool, bound to the top level
`include "timer_slot_pool_with_watchers_macros.svh"

module tspw_checker (
   input logic         clock,
   input logic         reset,
   tspw_req_if.sink    req_bus,
   tspw_rsp_if.source  rsp_bus
);
   import tspw_pkg::*;

   // a stalled response beat holds
   `TSPW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid && $stable(rsp_bus.slot_index) && $stable(rsp_bus.alloc_failed) && $stable(rsp_bus.expired_slots) && $stable(rsp_bus.busy_slots) && $stable(rsp_bus.watchers_running), "response beat changed while stalled")

   // a failed start claims nothing and frees nothing
   `TSPW_ASSERT_NOW(a_fail_quiet, clock, reset, rsp_bus.valid && rsp_bus.alloc_failed, (rsp_bus.slot_index == '0) && (rsp_bus.expired_slots == '0), "failed start reported a slot")

   // a slot that expired is no longer busy
   `TSPW_ASSERT_NOW(a_expired_free, clock, reset, rsp_bus.valid, (rsp_bus.expired_slots & rsp_bus.busy_slots) == '0, "expired slot still busy")

   // one request in flight: no back-to-back request beats
   `TSPW_ASSERT_NEXT(a_one_in_flight, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "request taken while another is in flight")

endmodule

bind timer_slot_pool_with_watchers tspw_checker u_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

FILE: sim/tb_timer_slot_pool_with_watchers.sv
// testbench of the timer slot pool: directed and random request beats checked against a predictor
module tb_timer_slot_pool_with_watchers;
   timeunit 1ns;
   timeprecision 1ps;
   import tspw_pkg::*;

   localparam int SLOTS         = SLOT_COUNT_DEFAULT;
   localparam int WATCHERS      = WATCHER_COUNT_DEFAULT;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic [SIDX_W-1:0] slot_index;
      logic              alloc_failed;
      logic [MASK_W-1:0] expired_slots;
      logic [MASK_W-1:0] busy_slots;
      logic [RUN_W-1:0]  watchers_running;
   } status_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tspw_req_if req_if ();
   tspw_rsp_if rsp_if ();
   tspw_csr_if csr_if ();

   timer_slot_pool_with_watchers i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always #6 clock = ~clock;

   // predicted pool state
   logic [DUR_W-1:0] slot_left [SLOTS];
   logic [SLOTS-1:0] slot_taken;
   logic [DUR_W-1:0] watch_left [WATCHERS];
   logic [RES_W-1:0] res_us;

   status_beat_type status_q [$];
   int           mismatches    = 0;
   int           rsp_count     = 0;
   int           burst_left    = 0;
   bit           steady_sender = 1'b0;
   int           hold_request  = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns response %0d %s: got %0h want %0h", $time, rsp_count, what, got, want);
      mismatches++;
   endtask

   function automatic logic [DUR_W-1:0] ticks_for(input logic [DUR_W-1:0] us);
      logic [DUR_W-1:0] div;
      logic [DUR_W-1:0] q;
      div = (res_us == '0) ? DUR_W'(1) : DUR_W'(res_us);
      q = us / div;
      if ((us % div) != '0) q = q + 1;
      return q;
   endfunction

   function automatic status_beat_type predict_status(input cmd_type cmd,
                                                      input logic [DUR_W-1:0] dur,
                                                      input logic [WIDX_W-1:0] widx);
      status_beat_type  st;
      logic [DUR_W-1:0] t;
      int               free_slot;
      st = '0;
      case (cmd)
         CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_taken[i]) begin
                  if (slot_left[i] != '0) slot_left[i] = slot_left[i] - 1;
                  if (slot_left[i] == '0) begin
                     slot_taken[i] = 1'b0;
                     st.expired_slots[i] = 1'b1;
                  end
               end
            end
            for (int i = 0; i < WATCHERS; i++) begin
               if (watch_left[i] != '0) watch_left[i] = watch_left[i] - 1;
            end
         end
         CMD_START: begin
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!slot_taken[i]) free_slot = i;
            end
            if (free_slot < 0) begin
               st.alloc_failed = 1'b1;
            end else begin
               t = ticks_for(dur);
               st.slot_index = SIDX_W'(free_slot);
               slot_left[free_slot] = t;
               // zero ticks: claimed and released in the same beat
               if (t == '0) st.expired_slots[free_slot] = 1'b1;
               else slot_taken[free_slot] = 1'b1;
            end
         end
         CMD_LOAD: begin
            watch_left[widx % WATCHERS] = ticks_for(dur);
         end
         default: begin
         end
      endcase
      st.busy_slots = slot_taken;
      for (int i = 0; i < WATCHERS; i++) st.watchers_running[i] = (watch_left[i] != '0);
      return st;
   endfunction

   always @(posedge clock) begin : scoreboard
      status_beat_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_left[i] = '0;
         for (int i = 0; i < WATCHERS; i++) watch_left[i] = '0;
         slot_taken = '0;
         res_us = RES_RESET;
         status_q.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_count++;
            if (status_q.size() == 0) begin
               report_mismatch("response with nothing pending", 0, 0);
            end else begin
               want = status_q.pop_front();
               if (rsp_if.slot_index !== want.slot_index)
                  report_mismatch("slot_index", 32'(rsp_if.slot_index),
                                  32'(want.slot_index));
               if (rsp_if.alloc_failed !== want.alloc_failed)
                  report_mismatch("alloc_failed", 32'(rsp_if.alloc_failed),
                                  32'(want.alloc_failed));
               if (rsp_if.expired_slots !== want.expired_slots)
                  report_mismatch("expired_slots", 32'(rsp_if.expired_slots),
                                  32'(want.expired_slots));
               if (rsp_if.busy_slots !== want.busy_slots)
                  report_mismatch("busy_slots", 32'(rsp_if.busy_slots),
                                  32'(want.busy_slots));
               if (rsp_if.watchers_running !== want.watchers_running)
                  report_mismatch("watchers_running", 32'(rsp_if.watchers_running),
                                  32'(want.watchers_running));
            end
         end
         if (csr_if.valid && csr_if.ready) res_us = csr_if.tick_resolution_us;
         if (req_if.valid && req_if.ready)
            status_q.push_back(predict_status(cmd_type'(req_if.command), req_if.duration_us,
                                              req_if.watcher_index));
      end
   end

   // receiver: stretches of differing ready density, plus an optional long hold-off
   initial begin : receiver
      int stretch_left;
      int ready_pct;
      int hold_left;
      stretch_left = 0;
      ready_pct = 100;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (stretch_left <= 0) begin
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 50;
                  2: ready_pct = 20;
                  default: ready_pct = 85;
               endcase
               stretch_left = $urandom_range(10, 150);
            end
            stretch_left--;
            rsp_if.ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   task automatic send_req(input cmd_type cmd, input logic [DUR_W-1:0] dur,
                           input logic [WIDX_W-1:0] widx);
      int gap;
      if (!steady_sender && burst_left <= 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 45) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_if.valid         <= 1'b1;
      req_if.command       <= cmd;
      req_if.duration_us   <= dur;
      req_if.watcher_index <= widx;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      // first let the scoreboard see the last accepted beat, so it is already predicted
      @(posedge clock);
      while (status_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_resolution(input logic [RES_W-1:0] value);
      wait_drained();
      csr_if.valid              <= 1'b1;
      csr_if.tick_resolution_us <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic test_idle_status();
      send_req(CMD_TICK, '0, '0);
      send_req(CMD_NOP, '1, '1);
   endtask

   task automatic test_pool_exhaustion();
      logic [DUR_W-1:0] durs [10];
      durs = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 1};
      // the first start frees at once, eight fill the pool, the last one fails
      foreach (durs[i]) send_req(CMD_START, durs[i], WIDX_W'(i));
      repeat (3) send_req(CMD_TICK, '0, '0);
   endtask

   task automatic test_watcher_extremes();
      write_resolution('0);
      send_req(CMD_LOAD, '1, 2'd0);
      send_req(CMD_LOAD, 32'd2, 2'd1);
      send_req(CMD_LOAD, 32'd1, 2'd2);
      send_req(CMD_LOAD, '0, 2'd3);
      send_req(CMD_TICK, '0, '0);
      send_req(CMD_TICK, '0, '0);
      send_req(CMD_LOAD, '0, 2'd0);
      write_resolution('1);
      send_req(CMD_LOAD, '1, 2'd3);
      send_req(CMD_START, 32'd256, '0);
      send_req(CMD_START, 32'd255, '0);
      send_req(CMD_TICK, '0, '0);
      send_req(CMD_TICK, '0, '0);
      send_req(CMD_LOAD, '0, 2'd3);
   endtask

   task automatic test_random_traffic(input int n, input logic [RES_W-1:0] res);
      int unsigned      pick;
      int unsigned      scale;
      logic [DUR_W-1:0] dur;
      write_resolution(res);
      scale = (res == '0) ? 1 : res;
      for (int k = 0; k < n; k++) begin
         if (k % 100 == 0) steady_sender = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         dur = $urandom_range(0, scale * 12);
         if (pick < 45) send_req(CMD_TICK, $urandom(), WIDX_W'($urandom_range(0, 3)));
         else if (pick < 75)
            send_req(CMD_START, (pick < 50) ? '0 : dur, WIDX_W'($urandom_range(0, 3)));
         else if (pick < 88) send_req(CMD_LOAD, dur, WIDX_W'($urandom_range(0, 3)));
         else if (pick < 95) send_req(CMD_LOAD, $urandom(), WIDX_W'($urandom_range(0, 3)));
         else send_req(CMD_NOP, $urandom(), WIDX_W'($urandom_range(0, 3)));
      end
      steady_sender = 1'b0;
   endtask

   task automatic test_backpressure();
      write_resolution(RES_W'($urandom_range(1, 8)));
      steady_sender = 1'b1;
      hold_request = HOLD_CYCLES;
      repeat (12) begin
         if ($urandom_range(0, 1) == 0) send_req(CMD_TICK, '0, '0);
         else send_req(CMD_LOAD, $urandom_range(0, 40), WIDX_W'($urandom_range(0, 3)));
      end
      steady_sender = 1'b0;
   endtask

   task automatic test_full_width_starts();
      int free_slots;
      write_resolution(RES_W'($urandom_range(1, 255)));
      free_slots = SLOTS - $countones(slot_taken);
      // these slots never run out, so this goes last
      repeat (free_slots + 2) send_req(CMD_START, $urandom() | 32'h8000_0000, '0);
      send_req(CMD_START, $urandom(), '0);
      repeat (4) send_req(CMD_TICK, '0, '0);
      send_req(CMD_LOAD, '1, WIDX_W'($urandom_range(0, 3)));
      send_req(CMD_NOP, '0, '0);
   endtask

   initial begin : stimulus
      req_if.valid              = 1'b0;
      req_if.command            = CMD_TICK;
      req_if.duration_us        = '0;
      req_if.watcher_index      = '0;
      csr_if.valid              = 1'b0;
      csr_if.tick_resolution_us = RES_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_idle_status();
      test_pool_exhaustion();
      test_watcher_extremes();
      test_random_traffic(220, 8'd1);
      test_random_traffic(220, 8'd255);
      test_random_traffic(250, RES_W'($urandom_range(2, 254)));
      test_backpressure();
      test_random_traffic(120, 8'd0);
      test_random_traffic(200, RES_W'($urandom_range(1, 16)));
      test_random_traffic(100, RES_RESET);
      test_full_width_starts();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (status_q.size() != 0) report_mismatch("responses never arrived", status_q.size(), 0);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #(10_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
